// File: rtl/smsd_pkg.sv
// Shared constants, types and helpers for the sliding median spike detector.
`default_nettype none
package smsd_pkg;
    localparam int VALUE_BINS = 256;
    localparam int MAX_WINDOW = 1024;
    localparam int BIN_W      = $clog2(VALUE_BINS);
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 11;
    localparam int TWICE_W    = 9;
    localparam int TOTAL_W    = 32;

    typedef struct packed {
        logic             re;
        logic [BIN_W-1:0] raddr;
        logic             we;
        logic [BIN_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
    } t_hist_req;

    // window length as used: zero acts as one, large values clamp
    function automatic logic [LEN_W-1:0] eff_window(input logic [LEN_W-1:0] w);
        logic [LEN_W-1:0] r;
        r = w;
        if (w == '0) r = LEN_W'(1);
        else if (w > LEN_W'(MAX_WINDOW)) r = LEN_W'(MAX_WINDOW);
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/smsd_hist_ram.sv
// Histogram memory: one read and one write port, registered read, per-bin valid bits.
`default_nettype none
module smsd_hist_ram import smsd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire t_hist_req        i_req,
    output logic      [CNT_W-1:0] o_rd_data
);
    logic [CNT_W-1:0]      mem [VALUE_BINS];
    logic [VALUE_BINS-1:0] r_valid;
    logic [CNT_W-1:0]      r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    // a bin never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;
endmodule
`default_nettype wire

// File: rtl/smsd_ring_ram.sv
// Sample ring memory: one write and one registered read port.
`default_nettype none
module smsd_ring_ram import smsd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [PTR_W-1:0] i_waddr,
    input  wire logic [BIN_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [PTR_W-1:0] i_raddr,
    output logic      [BIN_W-1:0] o_rd_data
);
    logic [BIN_W-1:0] mem [MAX_WINDOW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rd_data <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/smsd_scan.sv
// Cumulative histogram scan that finds twice the window median.
`default_nettype none
module smsd_scan import smsd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_vld,
    input  wire logic [BIN_W-1:0]   i_idx,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [LEN_W-1:0]   i_n,
    output logic      [TWICE_W-1:0] o_twice
);
    logic [CNT_W-1:0]   r_cum, n_cum;
    logic [BIN_W-1:0]   r_lower, n_lower;
    logic               r_have_lower, n_have_lower;
    logic               r_found, n_found;
    logic [TWICE_W-1:0] r_twice, n_twice;
    logic [LEN_W-1:0]   half;

    assign half = {1'b0, i_n[LEN_W-1:1]};

    always_comb begin
        n_cum        = r_cum;
        n_lower      = r_lower;
        n_have_lower = r_have_lower;
        n_found      = r_found;
        n_twice      = r_twice;
        if (i_vld && !r_found) begin
            n_cum = r_cum + i_count;
            if (i_n[0]) begin
                if (n_cum > half) begin
                    n_found = 1'b1;
                    n_twice = {i_idx, 1'b0};
                end
            end else begin
                if (!r_have_lower && n_cum >= half) begin
                    n_lower      = i_idx;
                    n_have_lower = 1'b1;
                end
                if (n_cum >= half + LEN_W'(1)) begin
                    n_found = 1'b1;
                    n_twice = {1'b0, n_lower} + {1'b0, i_idx};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_cum        <= '0;
            r_lower      <= '0;
            r_have_lower <= 1'b0;
            r_found      <= 1'b0;
            r_twice      <= '0;
        end else begin
            r_cum        <= n_cum;
            r_lower      <= n_lower;
            r_have_lower <= n_have_lower;
            r_found      <= n_found;
            r_twice      <= n_twice;
        end
    end

    assign o_twice = r_twice;
endmodule
`default_nettype wire

// File: rtl/sliding_median_spike_detector.sv
// Sliding median spike detector: control sequencer around the histogram and ring memories.
// While the window fills, a word passes S_ADD_RD, S_ADD and S_OUT; once full it first passes
// S_SCAN, S_DRAIN, S_OLD and S_DEC. One word is in flight at a time; a full window
// reads one histogram bin per cycle over all 256 bins, then read-modify-writes two bins.
// The next word is accepted while a finished result waits in the output register.
// Reset (synchronous, active low): window length 1, empty window, count zero.
`default_nettype none
module sliding_median_spike_detector import smsd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]   i_window_length,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [BIN_W-1:0]   i_sample_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_window_full,
    output logic      [TWICE_W-1:0] o_twice_median,
    output logic                    o_notify,
    output logic      [TOTAL_W-1:0] o_notify_total
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_OLD, S_DEC, S_ADD_RD, S_ADD, S_OUT
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_window_len;
    logic [PTR_W-1:0]   r_ptr;
    logic [LEN_W-1:0]   r_fill;
    logic [TOTAL_W-1:0] r_alert;
    logic [PTR_W-1:0]   r_slot;
    logic [BIN_W-1:0]   r_bin;
    logic [BIN_W-1:0]   r_old;
    logic [BIN_W-1:0]   r_scan_addr;
    logic [BIN_W-1:0]   r_proc_idx;
    logic               r_proc_vld;
    logic               r_res_full;
    logic [TWICE_W-1:0] r_res_twice;
    logic               r_res_note;

    logic [LEN_W-1:0]   win_n;
    logic [PTR_W-1:0]   acc_slot;
    logic [LEN_W-1:0]   slot_inc;
    logic               in_acc;
    logic               out_free;
    t_hist_req          hist_req;
    logic [CNT_W-1:0]   hist_rd;
    logic               ring_re;
    logic [BIN_W-1:0]   ring_rd;
    logic [TWICE_W-1:0] scan_twice;
    logic               note;

    assign win_n      = eff_window(r_window_len);
    assign acc_slot   = ({1'b0, r_ptr} >= win_n) ? '0 : r_ptr;
    assign slot_inc   = {1'b0, r_slot} + LEN_W'(1);
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_wr_en;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;
    assign note       = ({1'b0, r_bin} >= scan_twice);
    assign ring_re    = (r_state == S_DRAIN);

    always_comb begin
        hist_req = '0;
        unique case (r_state)
            S_SCAN: begin
                hist_req.re    = 1'b1;
                hist_req.raddr = r_scan_addr;
            end
            S_OLD: begin
                hist_req.re    = 1'b1;
                hist_req.raddr = ring_rd;
            end
            S_DEC: begin
                hist_req.we    = 1'b1;
                hist_req.waddr = r_old;
                hist_req.wdata = (hist_rd == '0) ? '0 : hist_rd - CNT_W'(1);
            end
            S_ADD_RD: begin
                hist_req.re    = 1'b1;
                hist_req.raddr = r_bin;
            end
            S_ADD: begin
                hist_req.we    = 1'b1;
                hist_req.waddr = r_bin;
                hist_req.wdata = hist_rd + CNT_W'(1);
            end
            default: hist_req = '0;
        endcase
    end

    smsd_hist_ram u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_wr_en),
        .i_req     (hist_req),
        .o_rd_data (hist_rd)
    );

    smsd_ring_ram u_ring (
        .i_clk     (i_clk),
        .i_we      (r_state == S_ADD),
        .i_waddr   (r_slot),
        .i_wdata   (r_bin),
        .i_re      (ring_re),
        .i_raddr   (r_slot),
        .o_rd_data (ring_rd)
    );

    smsd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_vld   (r_proc_vld),
        .i_idx   (r_proc_idx),
        .i_count (hist_rd),
        .i_n     (win_n),
        .o_twice (scan_twice)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_len   <= LEN_W'(1);
            r_ptr          <= '0;
            r_fill         <= '0;
            r_alert        <= '0;
            r_slot         <= '0;
            r_bin          <= '0;
            r_old          <= '0;
            r_scan_addr    <= '0;
            r_proc_idx     <= '0;
            r_proc_vld     <= 1'b0;
            r_res_full     <= 1'b0;
            r_res_twice    <= '0;
            r_res_note     <= 1'b0;
            o_out_valid    <= 1'b0;
            o_window_full  <= 1'b0;
            o_twice_median <= '0;
            o_notify       <= 1'b0;
            o_notify_total <= '0;
        end else begin
            // S_OUT reloads the output register itself
            if (o_out_valid && i_out_ready && (r_state != S_OUT || i_cfg_wr_en)) begin
                o_out_valid <= 1'b0;
            end
            r_proc_vld <= (r_state == S_SCAN);
            if (i_cfg_wr_en) begin
                r_window_len <= i_window_length;
                r_ptr        <= '0;
                r_fill       <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_acc) begin
                            r_slot      <= acc_slot;
                            r_bin       <= i_sample_value;
                            r_scan_addr <= '0;
                            if (r_fill >= win_n) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_fill      <= r_fill + LEN_W'(1);
                                r_res_full  <= 1'b0;
                                r_res_twice <= '0;
                                r_res_note  <= 1'b0;
                                r_state     <= S_ADD_RD;
                            end
                        end
                    end
                    S_SCAN: begin
                        // read data returns next cycle, so the index trails the address
                        r_proc_idx  <= r_scan_addr;
                        r_scan_addr <= r_scan_addr + BIN_W'(1);
                        if (r_scan_addr == BIN_W'(VALUE_BINS - 1)) begin
                            r_state <= S_DRAIN;
                        end
                    end
                    S_DRAIN: begin
                        r_state <= S_OLD;
                    end
                    S_OLD: begin
                        r_old       <= ring_rd;
                        r_res_full  <= 1'b1;
                        r_res_twice <= scan_twice;
                        r_res_note  <= note;
                        if (note && r_alert != '1) begin
                            r_alert <= r_alert + TOTAL_W'(1);
                        end
                        r_state <= S_DEC;
                    end
                    S_DEC: begin
                        r_state <= S_ADD_RD;
                    end
                    S_ADD_RD: begin
                        r_state <= S_ADD;
                    end
                    S_ADD: begin
                        r_ptr   <= (slot_inc >= win_n) ? '0 : slot_inc[PTR_W-1:0];
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (out_free) begin
                            o_out_valid    <= 1'b1;
                            o_window_full  <= r_res_full;
                            o_twice_median <= r_res_twice;
                            o_notify       <= r_res_note;
                            o_notify_total <= r_alert;
                            r_state        <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/smsd_checker.sv
// Port-level checks for the sliding median spike detector, bound to the top level.
`default_nettype none
module smsd_checker import smsd_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_window_full,
    input wire logic [TWICE_W-1:0] o_twice_median,
    input wire logic               o_notify,
    input wire logic [TOTAL_W-1:0] o_notify_total
);
    logic [1:0]         r_pend;
    logic [TOTAL_W-1:0] r_last_total;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= '0;
            r_last_total <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                r_last_total <= o_notify_total;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_notify_total)
            && $stable(o_twice_median) && $stable(o_notify) && $stable(o_window_full))
        else $error("result word changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result without an accepted sample");

    a_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_full |-> o_twice_median == '0 && !o_notify)
        else $error("median or notify set before window full");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_notify_total == r_last_total + {31'd0, o_notify})
            || (r_last_total == '1 && o_notify_total == '1))
        else $error("notification count does not follow notify");
endmodule

bind sliding_median_spike_detector smsd_checker u_smsd_checker (.*);
`default_nettype wire
